/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files; nrlp_ctrl is the only user
// expects clk and arst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define NRLP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("nrlp assertion failed");

// same with a caller supplied message
`define NRLP_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

/* hw/rtl/nrlp_pkg.sv */
// types, constants and helper functions for the note record pixel writer
// no dependencies
package nrlp_pkg;

	typedef enum logic [2:0] {
		REG_ON_HUE          = 3'd0,
		REG_ON_SATURATION   = 3'd1,
		REG_OFF_HUE         = 3'd2,
		REG_OFF_SATURATION  = 3'd3,
		REG_OFF_VALUE       = 3'd4,
		REG_TOP_KEY         = 3'd5,
		REG_POSITION_OFFSET = 3'd6,
		REG_VELOCITY_OFFSET = 3'd7
	} reg_idx_t;

	localparam logic [8:0] RST_ON_HUE          = 9'd240;
	localparam logic [6:0] RST_ON_SATURATION   = 7'd80;
	localparam logic [8:0] RST_OFF_HUE         = 9'd30;
	localparam logic [6:0] RST_OFF_SATURATION  = 7'd89;
	localparam logic [6:0] RST_OFF_VALUE       = 7'd10;
	localparam logic [7:0] RST_TOP_KEY         = 8'd108;
	localparam logic [7:0] RST_POSITION_OFFSET = 8'd8;
	localparam logic [6:0] RST_VELOCITY_OFFSET = 7'd40;

	localparam logic [7:0] KIND_RELEASE = 8'd0;
	localparam logic [7:0] KIND_PRESS   = 8'd1;

	localparam logic [6:0] PCT_FULL = 7'd100;

	// reciprocal constants: 255/100 in q12, 1/100 in q22, 1/60 in q20
	localparam logic [13:0] SCALE_255_Q12 = 14'd10445;
	localparam logic [15:0] RECIP_100_Q22 = 16'd41944;
	localparam logic [14:0] RECIP_60_Q20  = 15'd17477;

	typedef struct packed {
		logic [8:0] on_hue;
		logic [6:0] on_saturation;
		logic [8:0] off_hue;
		logic [6:0] off_saturation;
		logic [6:0] off_value;
		logic [7:0] top_key;
		logic [7:0] position_offset;
		logic [6:0] velocity_offset;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic ld_kind;
		logic ld_key;
		logic ld_vel;
		logic sel;
		logic hi;
		logic lo_mul;
		logic lo_div;
		logic adj_mul;
		logic adj_div;
		logic rgb;
		logic advance;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic drop;
	} sts_t;

	typedef struct packed {
		logic [2:0] sector;
		logic [5:0] frac;
	} hue_split_t;

	function automatic logic [6:0] clamp_pct(input logic [6:0] x);
		clamp_pct = (x > PCT_FULL) ? PCT_FULL : x;
	endfunction

	// hue wrapped once below 360, then split into 60 degree sectors
	function automatic hue_split_t split_hue(input logic [8:0] h);
		logic [8:0] w;
		hue_split_t r;
		w = (h >= 9'd360) ? (h - 9'd360) : h;
		if (w >= 9'd300) begin
			r.sector = 3'd5;
			r.frac   = 6'(w - 9'd300);
		end else if (w >= 9'd240) begin
			r.sector = 3'd4;
			r.frac   = 6'(w - 9'd240);
		end else if (w >= 9'd180) begin
			r.sector = 3'd3;
			r.frac   = 6'(w - 9'd180);
		end else if (w >= 9'd120) begin
			r.sector = 3'd2;
			r.frac   = 6'(w - 9'd120);
		end else if (w >= 9'd60) begin
			r.sector = 3'd1;
			r.frac   = 6'(w - 9'd60);
		end else begin
			r.sector = 3'd0;
			r.frac   = 6'(w);
		end
		split_hue = r;
	endfunction

endpackage

/* hw/rtl/nrlp_dp.sv */
// datapath: record bytes, brightness and position, hsv to rgb with
// reciprocal multiplies, pixel output registers; uses nrlp_pkg
module nrlp_dp #(
	parameter int PIXEL_COUNT = 190
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nrlp_pkg::cfg_t cfg,
	input  nrlp_pkg::cmd_t cmd,
	output nrlp_pkg::sts_t sts,
	input  logic [7:0]    rx_byte,
	output logic [7:0]    pixel_index,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue
);
	import nrlp_pkg::*;

	localparam logic signed [10:0] CentreMax = 11'(PIXEL_COUNT - 2);

	logic [7:0] kind_q, key_q, vel_q;
	logic [2:0] sector_q;
	logic [5:0] frac_q;
	logic [6:0] sat_q, val_q;
	logic [7:0] hi_q, lo_q, adj_q;
	logic [14:0] lo_prod_q;
	logic [13:0] adj_prod_q;
	logic [7:0] pix_q, red_q, green_q, blue_q;

	logic is_press, is_release;
	logic signed [9:0] vdiff, vdiff_adj, vhalf, bright_raw;
	logic [6:0] bright;
	logic signed [10:0] centre;
	hue_split_t hs;
	logic [6:0] sat_sel, val_sel;
	logic [20:0] hi_full;
	logic [30:0] lo_full;
	logic [28:0] adj_full;
	logic [6:0] sat_inv;
	logic [7:0] span;

	assign is_press   = (kind_q == KIND_PRESS);
	assign is_release = (kind_q == KIND_RELEASE);

	// press brightness, halved with truncation toward zero
	assign vdiff      = $signed({2'b00, vel_q}) - $signed({3'b000, cfg.velocity_offset});
	assign vdiff_adj  = vdiff + $signed({9'd0, vdiff[9]});
	assign vhalf      = vdiff_adj >>> 1;
	assign bright_raw = vhalf + 10'sd10;
	always_comb begin
		if (bright_raw < 10'sd0) begin
			bright = 7'd0;
		end else if (bright_raw > 10'sd100) begin
			bright = PCT_FULL;
		end else begin
			bright = bright_raw[6:0];
		end
	end

	assign centre = (($signed({3'b000, cfg.top_key}) - $signed({3'b000, key_q})) <<< 1)
		+ $signed({3'b000, cfg.position_offset});

	assign sts.drop = !(is_press || is_release) || (centre < 11'sd1) || (centre > CentreMax);

	assign hs      = split_hue(is_press ? cfg.on_hue : cfg.off_hue);
	assign sat_sel = clamp_pct(is_press ? cfg.on_saturation : cfg.off_saturation);
	assign val_sel = is_press ? bright : clamp_pct(cfg.off_value);

	assign hi_full  = {14'd0, val_q} * {7'd0, SCALE_255_Q12};
	assign sat_inv  = PCT_FULL - sat_q;
	assign lo_full  = {16'd0, lo_prod_q} * {15'd0, RECIP_100_Q22};
	assign span     = hi_q - lo_q;
	assign adj_full = {15'd0, adj_prod_q} * {14'd0, RECIP_60_Q20};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
			key_q  <= '0;
		end else begin
			if (cmd.ld_kind) kind_q <= rx_byte;
			if (cmd.ld_key)  key_q  <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_vel) vel_q <= rx_byte;
		if (cmd.sel) begin
			sector_q <= hs.sector;
			frac_q   <= hs.frac;
			sat_q    <= sat_sel;
			val_q    <= val_sel;
			pix_q    <= 8'(centre - 11'sd1);
		end
		if (cmd.hi)      hi_q       <= hi_full[19:12];
		if (cmd.lo_mul)  lo_prod_q  <= {7'd0, hi_q} * {8'd0, sat_inv};
		if (cmd.lo_div)  lo_q       <= lo_full[29:22];
		if (cmd.adj_mul) adj_prod_q <= {6'd0, span} * {8'd0, frac_q};
		if (cmd.adj_div) adj_q      <= adj_full[27:20];
		if (cmd.rgb) begin
			unique case (sector_q)
				3'd0: begin red_q <= hi_q;         green_q <= lo_q + adj_q; blue_q <= lo_q;         end
				3'd1: begin red_q <= hi_q - adj_q; green_q <= hi_q;         blue_q <= lo_q;         end
				3'd2: begin red_q <= lo_q;         green_q <= hi_q;         blue_q <= lo_q + adj_q; end
				3'd3: begin red_q <= lo_q;         green_q <= hi_q - adj_q; blue_q <= hi_q;         end
				3'd4: begin red_q <= lo_q + adj_q; green_q <= lo_q;         blue_q <= hi_q;         end
				default: begin red_q <= hi_q;      green_q <= lo_q;         blue_q <= hi_q - adj_q; end
			endcase
		end
		if (cmd.advance) pix_q <= pix_q + 8'd1;
	end

	assign pixel_index = pix_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;

endmodule

/* hw/rtl/nrlp_ctrl.sv */
// controller: byte framing, sequencing of the color calculation, word emission
// uses nrlp_pkg and assert_macros.svh
`include "assert_macros.svh"

module nrlp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           last,
	output nrlp_pkg::cmd_t cmd,
	input  nrlp_pkg::sts_t sts
);
	import nrlp_pkg::*;

	typedef enum logic [3:0] {
		ST_BYTE,
		ST_SEL,
		ST_HI,
		ST_LO_MUL,
		ST_LO_DIV,
		ST_ADJ_MUL,
		ST_ADJ_DIV,
		ST_RGB,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] phase_q;
	logic [1:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_ready  = (state_q == ST_BYTE);
	assign out_valid = (state_q == ST_EMIT);
	assign last      = (cnt_q == 2'd2);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	always_comb begin
		cmd         = '0;
		cmd.ld_kind = in_acc && (phase_q != 2'd1) && (phase_q != 2'd2);
		cmd.ld_key  = in_acc && (phase_q == 2'd1);
		cmd.ld_vel  = in_acc && (phase_q == 2'd2);
		cmd.sel     = (state_q == ST_SEL);
		cmd.hi      = (state_q == ST_HI);
		cmd.lo_mul  = (state_q == ST_LO_MUL);
		cmd.lo_div  = (state_q == ST_LO_DIV);
		cmd.adj_mul = (state_q == ST_ADJ_MUL);
		cmd.adj_div = (state_q == ST_ADJ_DIV);
		cmd.rgb     = (state_q == ST_RGB);
		cmd.advance = out_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BYTE;
			phase_q <= 2'd0;
			cnt_q   <= 2'd0;
		end else begin
			unique case (state_q)
				ST_BYTE: begin
					if (in_acc) begin
						unique case (phase_q)
							2'd1: phase_q <= 2'd2;
							2'd2: begin
								phase_q <= 2'd0;
								state_q <= ST_SEL;
							end
							default: phase_q <= 2'd1;
						endcase
					end
				end
				ST_SEL:     state_q <= sts.drop ? ST_BYTE : ST_HI;
				ST_HI:      state_q <= ST_LO_MUL;
				ST_LO_MUL:  state_q <= ST_LO_DIV;
				ST_LO_DIV:  state_q <= ST_ADJ_MUL;
				ST_ADJ_MUL: state_q <= ST_ADJ_DIV;
				ST_ADJ_DIV: state_q <= ST_RGB;
				ST_RGB: begin
					state_q <= ST_EMIT;
					cnt_q   <= 2'd0;
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (last) begin
							state_q <= ST_BYTE;
							cnt_q   <= 2'd0;
						end else begin
							cnt_q <= cnt_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_BYTE;
			endcase
		end
	end

	`NRLP_ASSERT(a_no_overlap, out_valid |-> !in_ready)
	`NRLP_ASSERT_MSG(a_third_byte_busy, (in_acc && phase_q == 2'd2) |=> !in_ready, "record not started")
	`NRLP_ASSERT_MSG(a_run_continues, (out_acc && !last) |=> out_valid, "pixel run cut short")
	`NRLP_ASSERT_MSG(a_run_ends, (out_acc && last) |=> (in_ready && !out_valid), "pixel run overran")

endmodule

/* hw/rtl/note_record_to_led_pixels_core.sv */
// sequence: after the third byte of a record the controller runs seven color steps
// (sel, hi, lo_mul, lo_div, adj_mul, adj_div, rgb), then emits three pixel words at one
// per cycle while out_ready is high; a dropped record returns to byte framing.
// New bytes wait for the run to end; one multiply per cycle through hi, lo, adj.
// reset: arst_n asynchronous low, restores register defaults and byte framing
module note_record_to_led_pixels_core #(
	parameter int PIXEL_COUNT = 190
) (
	input  logic       clk,
	input  logic       arst_n,
	// byte input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	// pixel write channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] pixel_index,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       last_of_run,
	// configuration write port
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);
	import nrlp_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// configuration registers, narrowed to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_hue          <= RST_ON_HUE;
			cfg_q.on_saturation   <= RST_ON_SATURATION;
			cfg_q.off_hue         <= RST_OFF_HUE;
			cfg_q.off_saturation  <= RST_OFF_SATURATION;
			cfg_q.off_value       <= RST_OFF_VALUE;
			cfg_q.top_key         <= RST_TOP_KEY;
			cfg_q.position_offset <= RST_POSITION_OFFSET;
			cfg_q.velocity_offset <= RST_VELOCITY_OFFSET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ON_HUE:          cfg_q.on_hue          <= cfg_data;
				REG_ON_SATURATION:   cfg_q.on_saturation   <= cfg_data[6:0];
				REG_OFF_HUE:         cfg_q.off_hue         <= cfg_data;
				REG_OFF_SATURATION:  cfg_q.off_saturation  <= cfg_data[6:0];
				REG_OFF_VALUE:       cfg_q.off_value       <= cfg_data[6:0];
				REG_TOP_KEY:         cfg_q.top_key         <= cfg_data[7:0];
				REG_POSITION_OFFSET: cfg_q.position_offset <= cfg_data[7:0];
				REG_VELOCITY_OFFSET: cfg_q.velocity_offset <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// sequencer: framing of kind, key, velocity bytes and the color steps
	nrlp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last      (last_of_run),
		.cmd       (cmd),
		.sts       (sts)
	);

	// arithmetic and output word registers
	nrlp_dp #(
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.rx_byte     (rx_byte),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

endmodule
